// ===== src/vertex_face_collision_energy_top_assert.svh =====
// Assertion macros shared by the collision energy RTL.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef VERTEX_FACE_COLLISION_ENERGY_TOP_ASSERT_SVH
`define VERTEX_FACE_COLLISION_ENERGY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VFCE_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("vfce check failed");
// next-cycle implication
`define VFCE_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("vfce check failed");
`else
`define VFCE_ASSERT_IMP(lbl, pre, post)
`define VFCE_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ===== src/vfce_pkg.sv =====
// Shared constants and types of the collision energy block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vfce_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int COORD_FRAC_DEF  = 16;
  localparam int STIFF_W         = 32;
  localparam int REST_W          = 31;
  localparam int ENERGY_W        = 64;
  localparam int CFG_IDX_W       = 1;
  localparam logic [STIFF_W-1:0] STIFF_RESET = 32'h0001_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_OFFSET = 1'b1;

  // per-item flags carried beside the root and quotient pipelines
  typedef struct packed {
    logic degen;
    logic neg;
  } vfce_flags_t;
endpackage
`default_nettype wire

// ===== src/vfce_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side payload.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module vfce_sqrt #(
  parameter int RAD_W  = 132,
  parameter int SIDE_W = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [RAD_W-1:0]     rad_i,
  input  wire logic [SIDE_W-1:0]    side_i,
  output logic                      valid_o,
  output logic [RAD_W/2-1:0]        root_o,
  output logic [SIDE_W-1:0]         side_o
);
  localparam int ROOT_W = RAD_W / 2;

  logic              valid_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [ROOT_W+1:0] rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vin;
    logic [RAD_W-1:0]  rad_in;
    logic [ROOT_W+1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic [ROOT_W+1:0] rem_sh, trial, rem_d;
    logic [ROOT_W-1:0] root_d;
    logic              ge;

    if (k == 0) begin : g_first
      assign vin     = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = valid_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1-2*k -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign rem_d  = ge ? (rem_sh - trial) : rem_sh;
    assign root_d = {root_in[ROOT_W-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];
endmodule
`default_nettype wire

// ===== src/vfce_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Quotient must fit QUO_W bits. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module vfce_div #(
  parameter int NUM_W  = 99,
  parameter int DEN_W  = 66,
  parameter int QUO_W  = 34,
  parameter int SIDE_W = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [QUO_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]      side_o
);
  logic              valid_q [QUO_W];
  logic [QUO_W-1:0]  num_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic              vin;
    logic [QUO_W-1:0]  num_in;
    logic [DEN_W-1:0]  den_in, rem_in, rem_d;
    logic [QUO_W-1:0]  quo_in, quo_d;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    rem_sh, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign vin     = valid_i;
      assign num_in  = num_i[QUO_W-1:0];
      assign den_in  = den_i;
      assign rem_in  = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = valid_q[k-1];
      assign num_in  = num_q[k-1];
      assign den_in  = den_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign rem_sh = {rem_in, num_in[QUO_W-1-k]};
    assign diff   = rem_sh - {1'b0, den_in};
    assign ge     = (rem_sh >= {1'b0, den_in});
    assign rem_d  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    assign quo_d  = {quo_in[QUO_W-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k]  <= num_in;
        den_q[k]  <= den_in;
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];
endmodule
`default_nettype wire

// ===== src/vertex_face_collision_energy_top.sv =====
// Vertex-face collision energy: top level, cross product, dot products, energy.
// Depends on vfce_pkg, vfce_sqrt, vfce_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_face_collision_energy_top_assert.svh"
// Takes one vertex/triangle query per item and returns one energy item per query,
// in order. A new item is accepted every cycle while input is not held off, and
// each result passes through the pipeline stages and then the two-entry
// output buffer. The square root retires one root bit per stage and the divider one
// quotient bit per stage, and those two chains set the depth. Input is held off
// only while both output buffer entries are full and the sink is stalled.
// Configuration registers may be written only while no item is in flight.
module vertex_face_collision_energy_top
  import vfce_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // point_x/y/z, tri_a_x/y/z, tri_b_x/y/z, tri_c_x/y/z, zero pad
  input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // energy
  output logic [ENERGY_W-1:0]                     m_axis_tdata,
  // degenerate, saturated
  output logic [1:0]                              m_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]               cfg_addr_i,
  input  wire logic [STIFF_W-1:0]                 cfg_wdata_i
);
  localparam int W     = COORD_WIDTH;
  localparam int DW    = W + 1;          // coordinate difference
  localparam int PW    = 2 * DW;         // cross product term
  localparam int MSW   = PW + 1;         // normal component
  localparam int LOW   = DW;             // low split of a normal component
  localparam int HIW   = MSW - LOW;      // high split, signed
  localparam int HHW   = 2 * HIW;
  localparam int HLW   = HIW + LOW + 1;
  localparam int LLW   = 2 * LOW;
  localparam int THW   = DW + HIW;
  localparam int TLW   = DW + LOW + 1;
  localparam int SW    = 4 * W + 4;      // squared normal length
  localparam int SQ_W  = SW + 1;
  localparam int RW    = SW / 2;         // root
  localparam int DSW   = 3 * W + 4;      // signed distance numerator
  localparam int DDW   = DSW - 1;
  localparam int QW    = W + 2;          // distance magnitude
  localparam int SAW   = ((QW > REST_W) ? QW : REST_W) + 1;
  localparam int SSW   = SAW + 1;
  localparam int PRW   = 2 * SAW + STIFF_W;
  localparam int ESH   = 3 * COORD_FRAC_BITS - 32;
  localparam int SHR   = (ESH >= 0) ? ESH : 0;
  localparam int SHL   = (ESH < 0) ? -ESH : 0;
  localparam int EXT_W = PRW + SHL;
  localparam int FL_W  = $bits(vfce_flags_t);

  // ---------------- configuration ----------------
  logic [STIFF_W-1:0] stiff_q;
  logic [REST_W-1:0]  rest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= STIFF_RESET;
      rest_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_STIFFNESS:   stiff_q <= cfg_wdata_i;
        REG_REST_OFFSET: rest_q  <= cfg_wdata_i[REST_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic [1:0] cnt_q;
  logic       pipe_en;
  logic [6:1] vld_q;
  logic [3:1] ev_q;

  assign pipe_en       = (cnt_q != 2'd2) || m_axis_tready;
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[5:1], s_axis_tvalid};
    end
  end

  // ---------------- stage 1: edge and offset vectors ----------------
  logic signed [W-1:0]  pt [3];
  logic signed [W-1:0]  ta [3];
  logic signed [W-1:0]  tb [3];
  logic signed [W-1:0]  tc [3];
  logic signed [DW-1:0] ea_d [3], ec_d [3], t_d [3];
  logic signed [DW-1:0] ea_q [3], ec_q [3], t1_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i]   = s_axis_tdata[i*W +: W];
      ta[i]   = s_axis_tdata[(3+i)*W +: W];
      tb[i]   = s_axis_tdata[(6+i)*W +: W];
      tc[i]   = s_axis_tdata[(9+i)*W +: W];
      ea_d[i] = DW'(ta[i]) - DW'(tb[i]);
      ec_d[i] = DW'(tc[i]) - DW'(tb[i]);
      t_d[i]  = DW'(pt[i]) - DW'(tb[i]);
    end
  end

  // ---------------- stage 2: cross product terms ----------------
  logic signed [PW-1:0] pa_d [3], pb_d [3], pa_q [3], pb_q [3];
  logic signed [DW-1:0] t2_q [3];

  always_comb begin
    pa_d[0] = PW'(ea_q[1]) * PW'(ec_q[2]);
    pb_d[0] = PW'(ea_q[2]) * PW'(ec_q[1]);
    pa_d[1] = PW'(ea_q[2]) * PW'(ec_q[0]);
    pb_d[1] = PW'(ea_q[0]) * PW'(ec_q[2]);
    pa_d[2] = PW'(ea_q[0]) * PW'(ec_q[1]);
    pb_d[2] = PW'(ea_q[1]) * PW'(ec_q[0]);
  end

  // ---------------- stage 3: normal ----------------
  logic signed [MSW-1:0] m_d [3], m_q [3];
  logic signed [DW-1:0]  t3_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_d[i] = MSW'(pa_q[i]) - MSW'(pb_q[i]);
    end
  end

  // ---------------- stage 4: split partial products ----------------
  logic signed [HIW-1:0] mhi [3];
  logic        [LOW-1:0] mlo [3];
  logic signed [HHW-1:0] hh_d [3], hh_q [3];
  logic signed [HLW-1:0] hl_d [3], hl_q [3];
  logic        [LLW-1:0] ll_d [3], ll_q [3];
  logic signed [THW-1:0] th_d [3], th_q [3];
  logic signed [TLW-1:0] tl_d [3], tl_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mhi[i]  = m_q[i][MSW-1:LOW];
      mlo[i]  = m_q[i][LOW-1:0];
      hh_d[i] = HHW'(mhi[i]) * HHW'(mhi[i]);
      hl_d[i] = HLW'(mhi[i]) * HLW'({1'b0, mlo[i]});
      ll_d[i] = LLW'(mlo[i]) * LLW'(mlo[i]);
      th_d[i] = THW'(t3_q[i]) * THW'(mhi[i]);
      tl_d[i] = TLW'(t3_q[i]) * TLW'({1'b0, mlo[i]});
    end
  end

  // ---------------- stage 5: per-component square and dot terms ----------------
  logic signed [SQ_W-1:0] sq_d [3], sq_q [3];
  logic signed [DSW-1:0]  td_d [3], td_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = (SQ_W'(hh_q[i]) <<< (2 * LOW)) + (SQ_W'(hl_q[i]) <<< (LOW + 1))
              + SQ_W'(ll_q[i]);
      td_d[i] = (DSW'(th_q[i]) <<< LOW) + DSW'(tl_q[i]);
    end
  end

  // ---------------- stage 6: sums ----------------
  logic [SQ_W-1:0]       s_sum;
  logic [SW-1:0]         s_q;
  logic signed [DSW-1:0] dsum_d, dsum_q;

  assign s_sum  = sq_q[0] + sq_q[1] + sq_q[2];
  assign dsum_d = td_q[0] + td_q[1] + td_q[2];

  // payload registers of stages 1 to 6
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        ea_q[i] <= ea_d[i];
        ec_q[i] <= ec_d[i];
        t1_q[i] <= t_d[i];
        pa_q[i] <= pa_d[i];
        pb_q[i] <= pb_d[i];
        t2_q[i] <= t1_q[i];
        m_q[i]  <= m_d[i];
        t3_q[i] <= t2_q[i];
        hh_q[i] <= hh_d[i];
        hl_q[i] <= hl_d[i];
        ll_q[i] <= ll_d[i];
        th_q[i] <= th_d[i];
        tl_q[i] <= tl_d[i];
        sq_q[i] <= sq_d[i];
        td_q[i] <= td_d[i];
      end
      s_q    <= s_sum[SW-1:0];
      dsum_q <= dsum_d;
    end
  end

  // ---------------- normal length ----------------
  vfce_flags_t     sq_flags;
  logic [DSW-1:0]  dabs;
  logic [FL_W+DDW-1:0] rt_side_in, rt_side_out;
  logic            rt_valid;
  logic [RW-1:0]   root;

  assign sq_flags.degen = (s_q == '0);
  assign sq_flags.neg   = dsum_q[DSW-1];
  assign dabs           = sq_flags.neg ? -dsum_q : dsum_q;
  assign rt_side_in     = {sq_flags, dabs[DDW-1:0]};

  vfce_sqrt #(
    .RAD_W  (SW),
    .SIDE_W (FL_W + DDW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (vld_q[6]),
    .rad_i   (s_q),
    .side_i  (rt_side_in),
    .valid_o (rt_valid),
    .root_o  (root),
    .side_o  (rt_side_out)
  );

  // ---------------- distance ----------------
  logic           dv_valid;
  logic [QW-1:0]  quo;
  vfce_flags_t    dv_flags;

  vfce_div #(
    .NUM_W  (DDW),
    .DEN_W  (RW),
    .QUO_W  (QW),
    .SIDE_W (FL_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (rt_valid),
    .num_i   (rt_side_out[DDW-1:0]),
    .den_i   (root),
    .side_i  (rt_side_out[FL_W+DDW-1:DDW]),
    .valid_o (dv_valid),
    .quo_o   (quo),
    .side_o  (dv_flags)
  );

  // ---------------- energy stage 1: offset and magnitude ----------------
  logic [SSW-1:0] dval, sval, sabs;
  logic [SAW-1:0] sa_q;
  logic [3:1]     edg_q;

  always_comb begin
    if (dv_flags.degen) begin
      dval = '0;
    end else if (dv_flags.neg) begin
      dval = -SSW'(quo);
    end else begin
      dval = SSW'(quo);
    end
    sval = dval - SSW'(rest_q);
    sabs = sval[SSW-1] ? -sval : sval;
  end

  // ---------------- energy stage 2: square ----------------
  logic [2*SAW-1:0] ssq_d, ssq_q;
  assign ssq_d = (2*SAW)'(sa_q) * (2*SAW)'(sa_q);

  // ---------------- energy stage 3: stiffness ----------------
  logic [SAW+STIFF_W-1:0] ph_d, pl_d, ph_q, pl_q;
  assign ph_d = (SAW+STIFF_W)'(ssq_q[2*SAW-1:SAW]) * (SAW+STIFF_W)'(stiff_q);
  assign pl_d = (SAW+STIFF_W)'(ssq_q[SAW-1:0]) * (SAW+STIFF_W)'(stiff_q);

  // ---------------- energy stage 4: combine, rescale, saturate ----------------
  logic [PRW-1:0]      prod;
  logic [EXT_W-1:0]    scaled;
  logic                sat;
  logic [ENERGY_W-1:0] energy;

  assign prod   = {ph_q, {SAW{1'b0}}} + PRW'(pl_q);
  assign scaled = (EXT_W'(prod) << SHL) >> SHR;
  assign sat    = |scaled[EXT_W-1:ENERGY_W];
  assign energy = sat ? '1 : scaled[ENERGY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= '0;
    end else if (pipe_en) begin
      ev_q <= {ev_q[2:1], dv_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sa_q  <= sabs[SAW-1:0];
      ssq_q <= ssq_d;
      ph_q  <= ph_d;
      pl_q  <= pl_d;
      edg_q <= {edg_q[2:1], dv_flags.degen};
    end
  end

  // ---------------- output buffer, two entries ----------------
  localparam int OB_W = ENERGY_W + 2;
  logic [OB_W-1:0] ob_new, ob0_q, ob1_q;
  logic [1:0]      cnt_d;
  logic            push, pop;

  assign ob_new = {sat, edg_q[3], energy};
  assign push   = pipe_en && ev_q[3];
  assign pop    = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !pop) begin
      if (cnt_q == 2'd0) begin
        ob0_q <= ob_new;
      end else begin
        ob1_q <= ob_new;
      end
    end else if (pop && !push) begin
      ob0_q <= ob1_q;
    end else if (push && pop) begin
      if (cnt_q == 2'd1) begin
        ob0_q <= ob_new;
      end else begin
        ob0_q <= ob1_q;
        ob1_q <= ob_new;
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = ob0_q[ENERGY_W-1:0];
  assign m_axis_tuser  = ob0_q[OB_W-1:ENERGY_W];

  // ---------------- checks ----------------
  `VFCE_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[1])
  `VFCE_ASSERT_IMP(a_sat_all_ones, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == '1)
  `VFCE_ASSERT_IMP(a_buf_bound, 1'b1, cnt_q != 2'd3)
  `VFCE_ASSERT_NXT(a_stall_holds, !pipe_en && vld_q[6], vld_q[6])
endmodule
`default_nettype wire
